// ===== design/ngfa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngfa_pkg: shared widths for the net gravity force accumulator
// Field widths, stream widths and iteration counts of the shared unit.
// ----------------------------------------------------------------------------
package ngfa_pkg;

    // Input field widths
    localparam int MASS_W = 15;
    localparam int POS_W  = 15;
    // Displacement carries one more bit than a position
    localparam int DISP_W = POS_W + 1;

    // Stream widths: six 15-bit fields padded to whole bytes, two 32-bit sums
    localparam int IN_TDATA_W  = 96;
    localparam int SUM_W       = 32;
    localparam int OUT_TDATA_W = 2 * SUM_W;

    // Iterative unit: root width, step counts, step counter width
    localparam int ROOT_W     = 16;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = SUM_W;
    localparam int CNT_W      = 5;

    // Shared multiplier operand widths
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

endpackage

// ===== design/net_gravity_force_accumulator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// net_gravity_force_accumulator_top: integer pairwise gravity force summing
// Each transfer pairs a body with one attracting body. The block forms the
// displacement, its squared length, the floor square root of that, then
// force = ((m1*m2)/dist) * disp / dist_sq per axis, with signed division that
// truncates toward zero, and adds the force to running X and Y sums.
// ----------------------------------------------------------------------------
// Usage: one input transfer gives one output transfer carrying the updated
// X and Y sums; tlast on the input marks the last attracting body, comes back
// as tlast on the output, and clears the sums after that result. An item
// passes through one shared shift-subtract unit that runs a 16-step square
// root and three 32-step divisions in turn (skipped when the two bodies
// coincide), plus a shared 32x18 multiplier for the squares and products.
// The input is ready only while the sequencer is idle; a finished result
// sits in an output register, so the next item is taken while that result
// still waits to be read.
// ----------------------------------------------------------------------------
module net_gravity_force_accumulator_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Slave side
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // tdata from bit 0: self_mass[14:0], self_x[29:15], self_y[44:30],
    // other_mass[59:45], other_x[74:60], other_y[89:75], zero pad [95:90]
    input  logic [ngfa_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    input  logic                              i_s_tlast,   // last_body
    // Master side
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // tdata from bit 0: force_x[31:0], force_y[63:32]
    output logic [ngfa_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    output logic                              o_m_tlast    // sum_done
);
    import ngfa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_ADD,
        S_RSET,
        S_SQRT,
        S_QSET,
        S_DIVQ,
        S_MULX,
        S_XSET,
        S_DIVX,
        S_MULY,
        S_YSET,
        S_DIVY,
        S_YEND,
        S_DONE
    } t_state;

    t_state                     r_state;

    // Captured item
    logic [MASS_W-1:0]          r_m1;
    logic [MASS_W-1:0]          r_m2;
    logic signed [DISP_W-1:0]   r_dx;
    logic signed [DISP_W-1:0]   r_dy;
    logic                       r_last;

    // Working registers
    logic signed [MUL_P_W-1:0]  r_prod;
    logic [SUM_W-1:0]           r_dsq;
    logic [SUM_W-1:0]           r_acc;
    logic [SUM_W-1:0]           r_rem;
    logic [SUM_W-1:0]           r_dvs;
    logic [ROOT_W-1:0]          r_root;
    logic [SUM_W-1:0]           r_quot;
    logic                       r_neg;
    logic [CNT_W-1:0]           r_cnt;
    logic [SUM_W-1:0]           r_fx;
    logic [SUM_W-1:0]           r_fy;

    // Running sums and output register
    logic [SUM_W-1:0]           r_sum_x;
    logic [SUM_W-1:0]           r_sum_y;
    logic                       r_tvalid;
    logic [OUT_TDATA_W-1:0]     r_tdata;
    logic                       r_tlast;

    // Combinational helpers
    logic                       w_in_xfer;
    logic signed [DISP_W-1:0]   w_dx;
    logic signed [DISP_W-1:0]   w_dy;
    logic signed [MUL_A_W-1:0]  w_mul_a;
    logic signed [MUL_B_W-1:0]  w_mul_b;
    logic signed [MUL_P_W-1:0]  w_mul_p;
    logic [SUM_W:0]             w_cand;
    logic [SUM_W:0]             w_sub;
    logic [SUM_W+1:0]           w_diff;
    logic                       w_ge;
    logic [SUM_W-1:0]           w_rem_nxt;
    logic [SUM_W-1:0]           w_num;
    logic [SUM_W-1:0]           w_qsigned;
    logic [SUM_W-1:0]           w_sum_x_nxt;
    logic [SUM_W-1:0]           w_sum_y_nxt;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_in_xfer  = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_tvalid;
    assign o_m_tdata  = r_tdata;
    assign o_m_tlast  = r_tlast;

    // Displacement other minus self, both sign-extended by one bit
    assign w_dx = $signed({i_s_tdata[74], i_s_tdata[74:60]})
                - $signed({i_s_tdata[29], i_s_tdata[29:15]});
    assign w_dy = $signed({i_s_tdata[89], i_s_tdata[89:75]})
                - $signed({i_s_tdata[44], i_s_tdata[44:30]});

    // Select shared multiplier operands
    always_comb begin
        unique case (r_state)
            S_SQX: begin
                w_mul_a = MUL_A_W'(r_dx);
                w_mul_b = MUL_B_W'(r_dx);
            end
            S_SQY: begin
                w_mul_a = MUL_A_W'(r_dy);
                w_mul_b = MUL_B_W'(r_dy);
            end
            S_RSET: begin
                w_mul_a = $signed(MUL_A_W'(r_m1));
                w_mul_b = $signed(MUL_B_W'(r_m2));
            end
            S_MULX: begin
                w_mul_a = $signed(r_acc);
                w_mul_b = MUL_B_W'(r_dx);
            end
            S_MULY: begin
                w_mul_a = $signed(r_quot);
                w_mul_b = MUL_B_W'(r_dy);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul_p = w_mul_a * w_mul_b;

    // Shared shift-subtract unit: root step takes two bits, divide step one
    always_comb begin
        if (r_state == S_SQRT) begin
            w_cand = {r_rem[SUM_W-2:0], r_acc[SUM_W-1 -: 2]};
            w_sub  = {(SUM_W - ROOT_W - 1)'(0), r_root, 2'b01};
        end else begin
            w_cand = {r_rem, r_acc[SUM_W-1]};
            w_sub  = {1'b0, r_dvs};
        end
        w_diff    = {1'b0, w_cand} - {1'b0, w_sub};
        w_ge      = ~w_diff[SUM_W+1];
        w_rem_nxt = w_ge ? w_diff[SUM_W-1:0] : w_cand[SUM_W-1:0];
    end

    // Divide operand magnitude, signed quotient, next sums
    assign w_num       = r_prod[SUM_W-1:0];
    assign w_qsigned   = r_neg ? (SUM_W'(0) - r_acc) : r_acc;
    assign w_sum_x_nxt = r_sum_x + r_fx;
    assign w_sum_y_nxt = r_sum_y + r_fy;

    // Sequencer, working registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tvalid <= 1'b0;
            r_sum_x  <= '0;
            r_sum_y  <= '0;
        end else begin
            // Drop the result once taken, unless a new one replaces it
            if (r_tvalid && i_m_tready && (r_state != S_DONE)) begin
                r_tvalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_m1    <= i_s_tdata[14:0];
                        r_m2    <= i_s_tdata[59:45];
                        r_dx    <= w_dx;
                        r_dy    <= w_dy;
                        r_last  <= i_s_tlast;
                        r_state <= S_SQX;
                    end
                end
                S_SQX: begin
                    r_prod  <= w_mul_p;
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_prod  <= w_mul_p;
                    r_dsq   <= r_prod[SUM_W-1:0];
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_dsq   <= r_dsq + r_prod[SUM_W-1:0];
                    r_state <= S_RSET;
                end
                S_RSET: begin
                    // Mass product now; coincident bodies skip to the sums
                    r_prod <= w_mul_p;
                    if (r_dsq == '0) begin
                        r_fx    <= '0;
                        r_fy    <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_acc   <= r_dsq;
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_cnt   <= CNT_W'(SQRT_STEPS - 1);
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_rem  <= w_rem_nxt;
                    r_root <= {r_root[ROOT_W-2:0], w_ge};
                    r_acc  <= {r_acc[SUM_W-3:0], 2'b00};
                    r_cnt  <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_QSET;
                    end
                end
                S_QSET: begin
                    r_acc   <= r_prod[SUM_W-1:0];
                    r_rem   <= '0;
                    r_dvs   <= SUM_W'(r_root);
                    r_cnt   <= CNT_W'(DIV_STEPS - 1);
                    r_state <= S_DIVQ;
                end
                S_DIVQ, S_DIVX, S_DIVY: begin
                    r_rem <= w_rem_nxt;
                    r_acc <= {r_acc[SUM_W-2:0], w_ge};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        priority case (r_state)
                            S_DIVQ:  r_state <= S_MULX;
                            S_DIVX:  r_state <= S_MULY;
                            default: r_state <= S_YEND;
                        endcase
                    end
                end
                S_MULX: begin
                    // Hold the quotient for the Y axis
                    r_prod  <= w_mul_p;
                    r_quot  <= r_acc;
                    r_state <= S_XSET;
                end
                S_XSET, S_YSET: begin
                    r_neg   <= w_num[SUM_W-1];
                    r_acc   <= w_num[SUM_W-1] ? (SUM_W'(0) - w_num) : w_num;
                    r_rem   <= '0;
                    r_dvs   <= r_dsq;
                    r_cnt   <= CNT_W'(DIV_STEPS - 1);
                    r_state <= (r_state == S_XSET) ? S_DIVX : S_DIVY;
                end
                S_MULY: begin
                    r_fx    <= w_qsigned;
                    r_prod  <= w_mul_p;
                    r_state <= S_YSET;
                end
                S_YEND: begin
                    r_fy    <= w_qsigned;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // Load the result once the output register is free
                    if (!r_tvalid || i_m_tready) begin
                        r_tvalid <= 1'b1;
                        r_tdata  <= {w_sum_y_nxt, w_sum_x_nxt};
                        r_tlast  <= r_last;
                        r_sum_x  <= r_last ? '0 : w_sum_x_nxt;
                        r_sum_y  <= r_last ? '0 : w_sum_y_nxt;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // An accepted item starts the sequence
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == S_SQX))
        else $error("accepted item did not start the sequence");

    // Coincident bodies never reach the square root
    a_no_zero_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT) |-> (r_dsq != '0))
        else $error("square root entered with zero squared length");

    // Square of the finished root does not exceed the squared length
    a_root_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QSET) |->
            ((SUM_W'(r_root) * SUM_W'(r_root)) <= r_dsq))
        else $error("square root too large");

    // Partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIVQ) || (r_state == S_DIVX) || (r_state == S_DIVY))
            |-> (r_rem < r_dvs))
        else $error("divider remainder out of range");

endmodule

// ===== dv/tb_net_gravity_force_accumulator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_net_gravity_force_accumulator_top: self-checking bench for the gravity
// force accumulator
// Drives body pairs into the slave stream and predicts the running X and Y
// force sums in the bench. Each output transfer is compared field by field
// with the oldest predicted sum. Directed pairs cover the field extremes,
// coincident bodies, truncation of negative quotients and wrapping sums.
// Random systems of one to eight attracting bodies follow. Both stream sides
// idle at random, with a stretch of full throughput.
// ----------------------------------------------------------------------------
module tb_net_gravity_force_accumulator_top;
    import ngfa_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RST_CYCLES   = 4;
    localparam int STALL_PCT    = 15;
    localparam int RANDOM_PAIRS = 1330;
    localparam int DRAIN_CYCLES = 300;
    localparam int STUCK_LIMIT  = 4000;
    localparam int POS_MIN      = -16384;
    localparam int POS_MAX      = 16383;
    localparam int MASS_MAX     = 32767;

    typedef struct {
        logic [MASS_W-1:0] self_mass;
        logic [POS_W-1:0]  self_x;
        logic [POS_W-1:0]  self_y;
        logic [MASS_W-1:0] other_mass;
        logic [POS_W-1:0]  other_x;
        logic [POS_W-1:0]  other_y;
        logic              last_body;
    } t_body_pair;

    typedef struct {
        logic [SUM_W-1:0] force_x;
        logic [SUM_W-1:0] force_y;
        logic             sum_done;
    } t_force_sum;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;
    logic                   i_s_tlast = 1'b0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tlast;

    // Bench copy of the running sums and the queue of predicted results
    logic [SUM_W-1:0] acc_x = '0;
    logic [SUM_W-1:0] acc_y = '0;
    t_force_sum       net_force_q[$];

    bit calm = 1'b0;
    int err_count = 0;
    int pairs_sent = 0;
    int systems_sent = 0;
    int coincident_sent = 0;
    int sums_checked = 0;
    int stuck_cycles = 0;

    net_gravity_force_accumulator_top u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tlast (i_s_tlast),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tlast (o_m_tlast)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Floor square root, one root bit per step from the top
    function automatic longint floor_root(input longint n);
        longint root;
        longint trial;
        root = 0;
        for (int b = ROOT_W - 1; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= n) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // Add the pair force to the sums and queue the expected output
    task automatic predict_net_force(input t_body_pair p);
        longint dx;
        longint dy;
        longint dsq;
        longint root_len;
        int quot;
        int fx;
        int fy;
        t_force_sum res;
        dx  = longint'($signed(p.other_x)) - longint'($signed(p.self_x));
        dy  = longint'($signed(p.other_y)) - longint'($signed(p.self_y));
        dsq = dx * dx + dy * dy;
        fx  = 0;
        fy  = 0;
        // Coincident bodies exert no force
        if (dsq != 0) begin
            root_len = floor_root(dsq);
            quot = int'(longint'(int'(longint'(p.self_mass) * longint'(p.other_mass)))
                        / root_len);
            fx   = int'(longint'(int'(longint'(quot) * dx)) / dsq);
            fy   = int'(longint'(int'(longint'(quot) * dy)) / dsq);
        end else begin
            coincident_sent++;
        end
        acc_x = acc_x + fx;
        acc_y = acc_y + fy;
        res.force_x  = acc_x;
        res.force_y  = acc_y;
        res.sum_done = p.last_body;
        net_force_q.push_back(res);
        if (p.last_body) begin
            acc_x = '0;
            acc_y = '0;
            systems_sent++;
        end
    endtask

    function automatic t_body_pair make_pair(input int m1, input int sx, input int sy,
                                             input int m2, input int ox, input int oy,
                                             input bit last);
        t_body_pair p;
        p.self_mass  = m1[MASS_W-1:0];
        p.self_x     = sx[POS_W-1:0];
        p.self_y     = sy[POS_W-1:0];
        p.other_mass = m2[MASS_W-1:0];
        p.other_x    = ox[POS_W-1:0];
        p.other_y    = oy[POS_W-1:0];
        p.last_body  = last;
        return p;
    endfunction

    // Offer one pair on the slave side and wait for its transfer
    task automatic send_pair(input t_body_pair p);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < STALL_PCT) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {6'b0, p.other_y, p.other_x, p.other_mass,
                       p.self_y, p.self_x, p.self_mass};
        i_s_tlast  <= p.last_body;
        do begin
            @(posedge i_clk);
        end while (!o_s_tready);
        predict_net_force(p);
        pairs_sent++;
    endtask

    task automatic release_input();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
    endtask

    // Field extremes, coincident bodies, sign and truncation cases
    task automatic test_directed_pairs();
        send_pair(make_pair(MASS_MAX, 5, -7, MASS_MAX, 5, -7, 1'b0));
        send_pair(make_pair(MASS_MAX, 0, 0, MASS_MAX, 1, 0, 1'b0));
        send_pair(make_pair(MASS_MAX, 0, 0, MASS_MAX, -1, 0, 1'b0));
        send_pair(make_pair(MASS_MAX, 0, 0, MASS_MAX, 0, 1, 1'b0));
        send_pair(make_pair(MASS_MAX, 0, 0, MASS_MAX, 0, -1, 1'b1));
        send_pair(make_pair(MASS_MAX, POS_MIN, POS_MIN, MASS_MAX, POS_MAX, POS_MAX, 1'b0));
        send_pair(make_pair(MASS_MAX, POS_MAX, POS_MAX, MASS_MAX, POS_MIN, POS_MIN, 1'b1));
        send_pair(make_pair(MASS_MAX, POS_MAX, POS_MIN, MASS_MAX, POS_MIN, POS_MAX, 1'b1));
        send_pair(make_pair(0, 0, 0, MASS_MAX, 2, 1, 1'b0));
        send_pair(make_pair(MASS_MAX, 0, 0, 0, -2, -1, 1'b1));
        send_pair(make_pair(1, 0, 0, 1, 1, 1, 1'b0));
        send_pair(make_pair(1, 0, 0, 1, -1, -1, 1'b1));
        // perfect square distance, then a rounded-down root
        send_pair(make_pair(1000, 10, 10, 2000, 13, 14, 1'b0));
        send_pair(make_pair(1000, 10, 10, 2000, 7, 7, 1'b0));
        send_pair(make_pair(MASS_MAX, -100, 50, 12345, -97, 47, 1'b1));
        // negative quotients truncate toward zero
        send_pair(make_pair(3, 0, 0, 5, -3, 2, 1'b0));
        send_pair(make_pair(7, 100, -100, 9, 95, -91, 1'b1));
        send_pair(make_pair(MASS_MAX, POS_MIN, 0, MASS_MAX, POS_MIN, 0, 1'b1));
        release_input();
    endtask

    // Large nearby forces drive the sums past the signed range
    task automatic test_sum_wrap();
        for (int k = 0; k < 3; k++) begin
            send_pair(make_pair(MASS_MAX, 0, 0, MASS_MAX, 1, 0, 1'b0));
        end
        for (int k = 0; k < 3; k++) begin
            send_pair(make_pair(MASS_MAX, 0, 0, MASS_MAX, 0, -1, k == 2));
        end
        release_input();
    endtask

    function automatic int clamp_pos(input int v);
        if (v < POS_MIN) return POS_MIN;
        if (v > POS_MAX) return POS_MAX;
        return v;
    endfunction

    function automatic int pick_mass();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) return 0;
        if (sel == 1) return MASS_MAX;
        return $urandom_range(0, MASS_MAX);
    endfunction

    // Random systems: one body against one to eight attracting bodies
    task automatic test_random_systems();
        int start_count;
        int n;
        int m1;
        int sx;
        int sy;
        int ox;
        int oy;
        int mode;
        int span;
        start_count = pairs_sent;
        while (pairs_sent - start_count < RANDOM_PAIRS) begin
            // hold full throughput for a stretch in the middle
            calm = (pairs_sent - start_count >= 500) && (pairs_sent - start_count < 700);
            n  = $urandom_range(1, 8);
            m1 = pick_mass();
            sx = $urandom_range(0, 32767) + POS_MIN;
            sy = $urandom_range(0, 32767) + POS_MIN;
            for (int k = 0; k < n; k++) begin
                mode = $urandom_range(0, 9);
                if (mode == 0) begin
                    ox = sx;
                    oy = sy;
                end else if (mode <= 4) begin
                    span = (mode <= 2) ? 4 : 256;
                    ox = clamp_pos(sx + $urandom_range(0, 2 * span) - span);
                    oy = clamp_pos(sy + $urandom_range(0, 2 * span) - span);
                end else begin
                    ox = $urandom_range(0, 32767) + POS_MIN;
                    oy = $urandom_range(0, 32767) + POS_MIN;
                end
                send_pair(make_pair(m1, sx, sy, pick_mass(), ox, oy, k == n - 1));
            end
        end
        calm = 1'b0;
        release_input();
    endtask

    // Randomly stall the master side
    always @(negedge i_clk) begin
        i_m_tready <= calm || ($urandom_range(0, 99) >= STALL_PCT);
    end

    // Compare each output transfer with the oldest predicted sum
    always @(posedge i_clk) begin
        t_force_sum exp_sum;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (net_force_q.size() == 0) begin
                $display("%0t: unexpected result x=%h y=%h last=%b",
                         $time, o_m_tdata[SUM_W-1:0], o_m_tdata[OUT_TDATA_W-1:SUM_W],
                         o_m_tlast);
                err_count++;
            end else begin
                exp_sum = net_force_q.pop_front();
                sums_checked++;
                if (o_m_tdata[SUM_W-1:0] !== exp_sum.force_x) begin
                    $display("%0t: force_x expected %h actual %h",
                             $time, exp_sum.force_x, o_m_tdata[SUM_W-1:0]);
                    err_count++;
                end
                if (o_m_tdata[OUT_TDATA_W-1:SUM_W] !== exp_sum.force_y) begin
                    $display("%0t: force_y expected %h actual %h",
                             $time, exp_sum.force_y, o_m_tdata[OUT_TDATA_W-1:SUM_W]);
                    err_count++;
                end
                if (o_m_tlast !== exp_sum.sum_done) begin
                    $display("%0t: sum_done expected %b actual %b",
                             $time, exp_sum.sum_done, o_m_tlast);
                    err_count++;
                end
            end
        end
    end

    // Abort when no transfer happens on either side for too long
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, STUCK_LIMIT, net_force_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_pairs();
        test_sum_wrap();
        test_random_systems();

        // drain outstanding results, then let the block settle
        while (net_force_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb: %0d body pairs in %0d systems sent, %0d with coincident bodies",
                 pairs_sent, systems_sent, coincident_sent);
        $display("tb: %0d force sums checked, %0d mismatches", sums_checked, err_count);
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/ngfa_pkg.sv
design/net_gravity_force_accumulator_top.sv
dv/tb_net_gravity_force_accumulator_top.sv
